/* src/xed_pkg.sv */
// constants shared by the entity decoder: entity spellings, lengths and replacement bytes
// no dependencies

package xed_pkg;

  typedef logic [7:0] char_t;

  localparam int HOLD_DEPTH = 5;
  localparam int NUM_ENT    = 4;
  localparam int ENT_MAX    = 6;
  localparam int RES_MAX    = 6;

  localparam char_t CH_AMP = 8'h26;

  localparam char_t ENT_TEXT [NUM_ENT][ENT_MAX] = '{
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}
  };

  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd6, 3'd4, 3'd4, 3'd5};

  localparam char_t ENT_CHAR [NUM_ENT] = '{8'h20, 8'h3C, 8'h3E, 8'h26};

endpackage

/* src/xml_entity_decoder_top.sv */
// streaming decoder for the entities &nbsp; &lt; &gt; &amp; on a byte stream
// depends on xed_pkg for the entity table

// One byte enters per cycle through an input register; a single combinational pass
// matches it against the held prefix and loads the result queue. A byte that gives
// zero or one result is done with in one pass, so plain text flows at one byte per cycle
// while out_ready is high. A byte that releases held bytes (a broken match or the end of
// a string) loads up to six bytes into the queue, and the input register stalls behind it.
// The result queue drains one byte per cycle while out_ready is high; out_run_last marks
// the last byte of each request and out_text_end the final byte of the decoded string.
module xml_entity_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // held prefix
  xed_pkg::char_t held_r [xed_pkg::HOLD_DEPTH];
  xed_pkg::char_t held_nxt [xed_pkg::HOLD_DEPTH];
  logic [2:0]     held_cnt_r;
  logic [2:0]     held_cnt_nxt;

  // result queue
  xed_pkg::char_t q_byte_r [xed_pkg::RES_MAX];
  logic [2:0]     q_cnt_r;
  logic           q_end_r;

  logic           proc;
  logic           out_take;
  logic [2:0]     len;
  xed_pkg::char_t cand [xed_pkg::ENT_MAX];
  xed_pkg::char_t res [xed_pkg::RES_MAX];
  logic [2:0]     res_cnt;
  logic           full;
  logic           prefix;
  xed_pkg::char_t full_char;
  logic           hold;
  logic           same;

  assign out_take = out_valid && out_ready;
  assign proc     = in_v_r && ((q_cnt_r == 3'd0) || ((q_cnt_r == 3'd1) && out_ready));
  assign in_ready = !in_v_r || proc;

  assign out_valid    = (q_cnt_r != 3'd0);
  assign out_byte     = q_byte_r[0];
  assign out_run_last = (q_cnt_r == 3'd1);
  assign out_text_end = (q_cnt_r == 3'd1) && q_end_r;

  always_comb begin
    len = held_cnt_r + 3'd1;
    for (int i = 0; i < xed_pkg::ENT_MAX; i++) begin
      cand[i] = (3'(i) < held_cnt_r && i < xed_pkg::HOLD_DEPTH) ?
                held_r[(i < xed_pkg::HOLD_DEPTH) ? i : 0] : in_byte_r;
    end

    full      = 1'b0;
    prefix    = 1'b0;
    full_char = xed_pkg::ENT_CHAR[0];
    for (int e = xed_pkg::NUM_ENT - 1; e >= 0; e--) begin
      same = (len <= xed_pkg::ENT_LEN[e]);
      for (int i = 0; i < xed_pkg::ENT_MAX; i++) begin
        if (3'(i) < len && cand[i] != xed_pkg::ENT_TEXT[e][i]) begin
          same = 1'b0;
        end
      end
      if (same && len == xed_pkg::ENT_LEN[e]) begin
        full      = 1'b1;
        full_char = xed_pkg::ENT_CHAR[e];
      end
      if (same && len < xed_pkg::ENT_LEN[e]) begin
        prefix = 1'b1;
      end
    end

    hold = !full && prefix && (held_cnt_r < 3'(xed_pkg::HOLD_DEPTH));

    for (int i = 0; i < xed_pkg::RES_MAX; i++) begin
      res[i] = cand[i];
    end
    for (int i = 0; i < xed_pkg::HOLD_DEPTH; i++) begin
      held_nxt[i] = held_r[i];
    end

    priority if (full) begin
      res[0]       = full_char;
      res_cnt      = 3'd1;
      held_cnt_nxt = 3'd0;
    end else if (hold) begin
      res_cnt = in_last_r ? len : 3'd0;
      for (int i = 0; i < xed_pkg::HOLD_DEPTH; i++) begin
        held_nxt[i] = cand[i];
      end
      held_cnt_nxt = len;
    end else begin
      // broken match: release held bytes, then handle the byte afresh
      if (in_byte_r == xed_pkg::CH_AMP) begin
        res_cnt      = in_last_r ? len : held_cnt_r;
        held_nxt[0]  = xed_pkg::CH_AMP;
        held_cnt_nxt = 3'd1;
      end else begin
        res_cnt      = len;
        held_cnt_nxt = 3'd0;
      end
    end

    if (in_last_r) begin
      held_cnt_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      held_cnt_r <= 3'd0;
      q_cnt_r    <= 3'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (proc) begin
        in_v_r <= 1'b0;
      end

      if (proc) begin
        held_cnt_r <= held_cnt_nxt;
        q_cnt_r    <= res_cnt;
      end else if (out_take) begin
        q_cnt_r <= q_cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
    if (proc) begin
      for (int i = 0; i < xed_pkg::HOLD_DEPTH; i++) begin
        held_r[i] <= held_nxt[i];
      end
      for (int i = 0; i < xed_pkg::RES_MAX; i++) begin
        q_byte_r[i] <= res[i];
      end
      q_end_r <= in_last_r;
    end else if (out_take) begin
      for (int i = 0; i < xed_pkg::RES_MAX - 1; i++) begin
        q_byte_r[i] <= q_byte_r[i + 1];
      end
    end
  end

endmodule
